// ===== rtl/ffba_pkg.sv =====
// Shared types, constants and command/status codes for the first-fit block allocator.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package ffba_pkg;

   // Table geometry.
   localparam int MAX_BLOCKS = 64;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;

   // Field widths.
   localparam int OFF_W  = 29;
   localparam int SIZE_W = 29;
   localparam int ADDR_W = 28;
   localparam int STAT_W = 3;

   // Heap constants.
   localparam logic [SIZE_W-1:0] HEADER_BYTES = 29'd32;
   localparam logic [SIZE_W-1:0] HEAP_BYTES   = 29'h1000_0000;
   localparam logic [SIZE_W-1:0] SIZE_4K      = 29'd4096;
   localparam logic [SIZE_W-1:0] SIZE_1M      = 29'd1048576;
   localparam logic [SIZE_W-1:0] SIZE_4M      = 29'd4194304;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_SIZE   = 3'd1,
      ST_OVER_AVAIL = 3'd2,
      ST_NO_FIT     = 3'd3,
      ST_FULL       = 3'd4,
      ST_BAD_FREE   = 3'd5
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // One table entry as kept in the block memory.
   typedef struct packed {
      logic [OFF_W-1:0]  off;
      logic [SIZE_W-1:0] size;
      logic              free;
   } entry_type;

   typedef enum logic [2:0] {
      RD_IDX,
      RD_IDX_NEXT,
      RD_IDX_PREV,
      RD_PTR_PREV,
      RD_PTR_NEXT
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_INIT,
      WR_SHIFT,
      WR_REMAINDER,
      WR_ALLOC,
      WR_CUR,
      WR_PREV_MERGE
   } wr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       idx_clr;
      logic       idx_inc;
      logic       ptr_cnt;
      logic       ptr_idx;
      logic       ptr_idx_next;
      logic       ptr_dec;
      logic       ptr_inc;
      logic       cur_load;
      logic       cur_free;
      logic       cur_merge;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       avail_alloc;
      logic       avail_free;
      logic       addr_set;
      logic       fin;
      status_type status;
      logic       rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   bad_size;
      logic   over_avail;
      logic   idx_at_cnt;
      logic   match;
      logic   cnt_full;
      logic   ptr_at_idx_next;
      logic   idx_next_in;
      logic   idx_zero;
      logic   rd_free;
      logic   ptr_last;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/ffba_req_if.sv =====
// Request channel interface: valid/ready handshake with the allocator request payload.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [ffba_pkg::SIZE_W-1:0]   request_size;
   logic [ffba_pkg::ADDR_W-1:0]   free_address;

   modport source (output valid, output op, output request_size, output free_address,
                   input ready);
   modport sink (input valid, input op, input request_size, input free_address,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/ffba_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the allocator result payload.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffba_pkg::STAT_W-1:0]   status;
   logic [ffba_pkg::ADDR_W-1:0]   address;
   logic [ffba_pkg::SIZE_W-1:0]   available_bytes;

   modport source (output valid, output status, output address, output available_bytes,
                   input ready);
   modport sink (input valid, input status, input address, input available_bytes,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/ffba_datapath.sv =====
// Datapath of the allocator: block table memory, counters, scan and merge arithmetic.
// Depends on ffba_pkg; driven by commands from ffba_ctrl.
`default_nettype none

module ffba_datapath (
   input  wire                            clock,
   input  wire                            reset,
   input  ffba_pkg::cmd_type              cmd,
   output ffba_pkg::stat_type             stat,
   input  wire                            in_op,
   input  wire [ffba_pkg::SIZE_W-1:0]     in_request_size,
   input  wire [ffba_pkg::ADDR_W-1:0]     in_free_address,
   output logic [ffba_pkg::STAT_W-1:0]    out_status,
   output logic [ffba_pkg::ADDR_W-1:0]    out_address,
   output logic [ffba_pkg::SIZE_W-1:0]    out_available_bytes
);

   // Block table memory.
   ffba_pkg::entry_type mem [ffba_pkg::MAX_BLOCKS];

   // Captured transaction.
   ffba_pkg::op_type                op_ff;
   logic [ffba_pkg::SIZE_W-1:0]     req_ff;
   logic [ffba_pkg::ADDR_W-1:0]     faddr_ff;

   // Scan index, shift pointer and table state.
   logic [ffba_pkg::CNT_W-1:0]      idx_ff;
   logic [ffba_pkg::CNT_W-1:0]      ptr_ff;
   logic [ffba_pkg::CNT_W-1:0]      cnt_ff;
   logic [ffba_pkg::SIZE_W-1:0]     avail_ff;
   ffba_pkg::entry_type             cur_ff;
   ffba_pkg::entry_type             rd_ff;

   // Result being built and the output register.
   ffba_pkg::status_type            status_ff;
   logic [ffba_pkg::ADDR_W-1:0]     addr_ff;
   logic [ffba_pkg::STAT_W-1:0]     rsp_status_ff;
   logic [ffba_pkg::ADDR_W-1:0]     rsp_addr_ff;
   logic [ffba_pkg::SIZE_W-1:0]     rsp_avail_ff;

   logic [ffba_pkg::SIZE_W:0]       need;
   logic [ffba_pkg::SIZE_W:0]       gain_sum;
   logic [ffba_pkg::SIZE_W:0]       cur_payload;
   logic [ffba_pkg::CNT_W-1:0]      idx_next;
   logic [ffba_pkg::CNT_W-1:0]      idx_prev;
   logic [ffba_pkg::CNT_W-1:0]      rd_addr;
   logic [ffba_pkg::CNT_W-1:0]      wr_addr;
   ffba_pkg::entry_type             wr_data;
   logic                            match_alloc;
   logic                            match_free;

   assign need     = {1'b0, req_ff} + {1'b0, ffba_pkg::HEADER_BYTES};
   assign idx_next = idx_ff + ffba_pkg::CNT_W'(1);
   assign idx_prev = idx_ff - ffba_pkg::CNT_W'(1);
   assign cur_payload = {1'b0, cur_ff.off} + {1'b0, ffba_pkg::HEADER_BYTES};
   assign gain_sum = {1'b0, avail_ff} + {1'b0, cur_ff.size} + {1'b0, ffba_pkg::HEADER_BYTES};

   // Match conditions on the entry just read.
   assign match_alloc = rd_ff.free && ({1'b0, rd_ff.size} >= need);
   assign match_free  = !rd_ff.free &&
                        (({1'b0, rd_ff.off} + {1'b0, ffba_pkg::HEADER_BYTES}) ==
                         {2'b00, faddr_ff});

   // Status toward the controller.
   always_comb begin
      stat.op              = op_ff;
      stat.bad_size        = (req_ff != ffba_pkg::SIZE_4K) && (req_ff != ffba_pkg::SIZE_1M) &&
                             (req_ff != ffba_pkg::SIZE_4M);
      stat.over_avail      = req_ff > avail_ff;
      stat.idx_at_cnt      = idx_ff == cnt_ff;
      stat.match           = (op_ff == ffba_pkg::OP_ALLOC) ? match_alloc : match_free;
      stat.cnt_full        = cnt_ff == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);
      stat.ptr_at_idx_next = ptr_ff == idx_next;
      stat.idx_next_in     = idx_next < cnt_ff;
      stat.idx_zero        = idx_ff == '0;
      stat.rd_free         = rd_ff.free;
      stat.ptr_last        = (ptr_ff + ffba_pkg::CNT_W'(1)) >= cnt_ff;
   end

   // Read address selection.
   always_comb begin
      case (cmd.rd_sel)
         ffba_pkg::RD_IDX_NEXT: rd_addr = idx_next;
         ffba_pkg::RD_IDX_PREV: rd_addr = idx_prev;
         ffba_pkg::RD_PTR_PREV: rd_addr = ptr_ff - ffba_pkg::CNT_W'(1);
         ffba_pkg::RD_PTR_NEXT: rd_addr = ptr_ff + ffba_pkg::CNT_W'(1);
         default:               rd_addr = idx_ff;
      endcase
   end

   // Write address and data selection.
   always_comb begin
      wr_addr = idx_ff;
      wr_data = cur_ff;
      case (cmd.wr_sel)
         ffba_pkg::WR_INIT: begin
            wr_addr = '0;
            wr_data = '{off: '0, size: ffba_pkg::HEAP_BYTES - ffba_pkg::HEADER_BYTES,
                        free: 1'b1};
         end
         ffba_pkg::WR_SHIFT: begin
            wr_addr = ptr_ff;
            wr_data = rd_ff;
         end
         ffba_pkg::WR_REMAINDER: begin
            wr_addr = idx_next;
            wr_data.off  = cur_ff.off + ffba_pkg::HEADER_BYTES + req_ff;
            wr_data.size = ffba_pkg::SIZE_W'({1'b0, cur_ff.size} - need);
            wr_data.free = 1'b1;
         end
         ffba_pkg::WR_ALLOC: begin
            wr_data.off  = cur_ff.off;
            wr_data.size = req_ff;
            wr_data.free = 1'b0;
         end
         ffba_pkg::WR_PREV_MERGE: begin
            wr_addr = idx_prev;
            wr_data.off  = rd_ff.off;
            wr_data.size = rd_ff.size + cur_ff.size + ffba_pkg::HEADER_BYTES;
            wr_data.free = 1'b1;
         end
         default: begin
            wr_addr = idx_ff;
            wr_data = cur_ff;
         end
      endcase
   end

   // Block table memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr[ffba_pkg::IDX_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr[ffba_pkg::IDX_W-1:0]];
      end
   end

   // Table count and available byte count.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= ffba_pkg::CNT_W'(1);
         avail_ff <= ffba_pkg::HEAP_BYTES - ffba_pkg::HEADER_BYTES;
      end else begin
         if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + ffba_pkg::CNT_W'(1);
         end else if (cmd.cnt_dec) begin
            cnt_ff <= cnt_ff - ffba_pkg::CNT_W'(1);
         end
         if (cmd.avail_alloc) begin
            avail_ff <= ({1'b0, avail_ff} >= need) ?
                        ffba_pkg::SIZE_W'({1'b0, avail_ff} - need) : '0;
         end else if (cmd.avail_free) begin
            avail_ff <= (gain_sum > {1'b0, ffba_pkg::HEAP_BYTES}) ?
                        ffba_pkg::HEAP_BYTES : gain_sum[ffba_pkg::SIZE_W-1:0];
         end
      end
   end

   // Transaction capture, index, pointer, current entry and result.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= ffba_pkg::op_type'(in_op);
         req_ff   <= in_request_size;
         faddr_ff <= in_free_address;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_next;
      end
      if (cmd.ptr_cnt) begin
         ptr_ff <= cnt_ff;
      end else if (cmd.ptr_idx) begin
         ptr_ff <= idx_ff;
      end else if (cmd.ptr_idx_next) begin
         ptr_ff <= idx_next;
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_ff - ffba_pkg::CNT_W'(1);
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + ffba_pkg::CNT_W'(1);
      end
      if (cmd.cur_load) begin
         cur_ff <= rd_ff;
      end else if (cmd.cur_merge) begin
         cur_ff.size <= cur_ff.size + rd_ff.size + ffba_pkg::HEADER_BYTES;
      end else if (cmd.cur_free) begin
         cur_ff.free <= 1'b1;
      end
      if (cmd.fin) begin
         status_ff <= cmd.status;
         addr_ff   <= cmd.addr_set ? cur_payload[ffba_pkg::ADDR_W-1:0] : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= addr_ff;
         rsp_avail_ff  <= avail_ff;
      end
   end

   assign out_status          = rsp_status_ff;
   assign out_address         = rsp_addr_ff;
   assign out_available_bytes = rsp_avail_ff;

endmodule

`default_nettype wire

// ===== rtl/ffba_ctrl.sv =====
// Controller state machine of the allocator: sequences scan, split, merge and table shifts.
// Depends on ffba_pkg; drives ffba_datapath through the command struct.
`default_nettype none

module ffba_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  ffba_pkg::stat_type   stat,
   output ffba_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_INS_RD,
      S_INS_WR,
      S_SPLIT_A,
      S_SPLIT_B,
      S_FREE_UPD,
      S_NEXT_CHK,
      S_REM_RD,
      S_REM_WR,
      S_PREV_RD,
      S_PREV_CHK,
      S_WR_CUR,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      tail_ff;
   logic      tail_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rd_sel   = ffba_pkg::RD_IDX;
      cmd.wr_sel   = ffba_pkg::WR_CUR;
      cmd.status   = ffba_pkg::ST_OK;
      unique case (state_ff)
         S_INIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ffba_pkg::WR_INIT;
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.op == ffba_pkg::OP_ALLOC && stat.bad_size) begin
               cmd.fin    = 1'b1;
               cmd.status = ffba_pkg::ST_BAD_SIZE;
               state_in   = S_RESP;
            end else if (stat.op == ffba_pkg::OP_ALLOC && stat.over_avail) begin
               cmd.fin    = 1'b1;
               cmd.status = ffba_pkg::ST_OVER_AVAIL;
               state_in   = S_RESP;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         // Walk the table one entry at a time: read the entry, then compare it.
         S_SCAN_RD: begin
            if (stat.idx_at_cnt) begin
               cmd.fin    = 1'b1;
               cmd.status = (stat.op == ffba_pkg::OP_ALLOC) ?
                            ffba_pkg::ST_NO_FIT : ffba_pkg::ST_BAD_FREE;
               state_in   = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffba_pkg::RD_IDX;
               state_in   = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (!stat.match) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else if (stat.op == ffba_pkg::OP_FREE) begin
               cmd.cur_load = 1'b1;
               state_in     = S_FREE_UPD;
            end else if (stat.cnt_full) begin
               cmd.fin    = 1'b1;
               cmd.status = ffba_pkg::ST_FULL;
               state_in   = S_RESP;
            end else begin
               cmd.cur_load = 1'b1;
               cmd.ptr_cnt  = 1'b1;
               state_in     = S_INS_RD;
            end
         end
         // Open a gap after the chosen block by moving later entries up.
         S_INS_RD: begin
            if (stat.ptr_at_idx_next) begin
               state_in = S_SPLIT_A;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffba_pkg::RD_PTR_PREV;
               state_in   = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = ffba_pkg::WR_SHIFT;
            cmd.ptr_dec = 1'b1;
            state_in    = S_INS_RD;
         end
         S_SPLIT_A: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ffba_pkg::WR_REMAINDER;
            state_in   = S_SPLIT_B;
         end
         S_SPLIT_B: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = ffba_pkg::WR_ALLOC;
            cmd.cnt_inc     = 1'b1;
            cmd.avail_alloc = 1'b1;
            cmd.fin         = 1'b1;
            cmd.addr_set    = 1'b1;
            cmd.status      = ffba_pkg::ST_OK;
            state_in        = S_RESP;
         end
         // Release: return the block to the available byte count, then try the next neighbor.
         S_FREE_UPD: begin
            cmd.avail_free = 1'b1;
            cmd.cur_free   = 1'b1;
            tail_in        = 1'b0;
            if (stat.idx_next_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffba_pkg::RD_IDX_NEXT;
               state_in   = S_NEXT_CHK;
            end else begin
               state_in = S_PREV_RD;
            end
         end
         S_NEXT_CHK: begin
            if (stat.rd_free) begin
               cmd.cur_merge    = 1'b1;
               cmd.ptr_idx_next = 1'b1;
               state_in         = S_REM_RD;
            end else begin
               state_in = S_PREV_RD;
            end
         end
         // Remove the entry at the pointer by moving later entries down.
         S_REM_RD: begin
            if (stat.ptr_last) begin
               cmd.cnt_dec = 1'b1;
               if (tail_ff) begin
                  cmd.fin    = 1'b1;
                  cmd.status = ffba_pkg::ST_OK;
                  state_in   = S_RESP;
               end else begin
                  state_in = S_PREV_RD;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffba_pkg::RD_PTR_NEXT;
               state_in   = S_REM_WR;
            end
         end
         S_REM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = ffba_pkg::WR_SHIFT;
            cmd.ptr_inc = 1'b1;
            state_in    = S_REM_RD;
         end
         S_PREV_RD: begin
            if (stat.idx_zero) begin
               state_in = S_WR_CUR;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffba_pkg::RD_IDX_PREV;
               state_in   = S_PREV_CHK;
            end
         end
         S_PREV_CHK: begin
            if (stat.rd_free) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = ffba_pkg::WR_PREV_MERGE;
               cmd.ptr_idx = 1'b1;
               tail_in     = 1'b1;
               state_in    = S_REM_RD;
            end else begin
               state_in = S_WR_CUR;
            end
         end
         S_WR_CUR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ffba_pkg::WR_CUR;
            cmd.fin    = 1'b1;
            cmd.status = ffba_pkg::ST_OK;
            state_in   = S_RESP;
         end
         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         tail_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tail_ff      <= tail_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator_top.sv =====
// First-fit block allocator with coalescing, top level.
// Instantiates ffba_ctrl and ffba_datapath; uses ffba_pkg, ffba_req_if and ffba_rsp_if.
//
// Usage: a request transaction carries op (allocate or free), request_size and
// free_address; each request produces exactly one response transaction with status,
// the payload address of an allocated block and the available byte count.
// Both channels use valid/ready; a transaction moves when both are high.
// One request is worked on at a time. A rejected size or a size above the
// available count is answered from the check itself, with no table scan.
// Otherwise the table scan visits the entries in order, each with a memory
// read and then a compare, and a split or merge moves table entries one at
// a time through the table memory, which has one write port and one
// registered read port. After reset the block writes the initial free block
// that spans the heap and then accepts requests. A finished response sits in
// an output register; the next request is accepted while it waits, and the
// block stalls only when a second response is ready and the first is still
// not taken.
`default_nettype none

module first_fit_block_allocator_top (
   input  wire              clock,
   input  wire              reset,
   ffba_req_if.sink         req,
   ffba_rsp_if.source       rsp
);

   ffba_pkg::cmd_type  cmd;
   ffba_pkg::stat_type stat;

   // Sequencing.
   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table and arithmetic.
   ffba_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .in_op               (req.op),
      .in_request_size     (req.request_size),
      .in_free_address     (req.free_address),
      .out_status          (rsp.status),
      .out_address         (rsp.address),
      .out_available_bytes (rsp.available_bytes)
   );

endmodule

`default_nettype wire
